/* sv/ccdr_pkg.sv */
// Package: shared widths, codes, state and struct types for the credit counter block.
`default_nettype none

package ccdr_pkg;

   // Default sizes
   localparam int VC_COUNT_DEF      = 4;
   localparam int PENDING_DEPTH_DEF = 8;

   // Field widths
   localparam int FUNC_W      = 2;
   localparam int VC_FIELD_W  = 2;
   localparam int AMOUNT_W    = 8;
   localparam int CREDIT_W    = 8;
   localparam int DELAY_W     = 4;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   // Due stamp: one bit wider than the delay so entries up to 16 ticks late still compare
   localparam int DUE_W       = DELAY_W + 1;

   // Register reset values
   localparam logic [CREDIT_W-1:0] CREDIT_LIMIT_RESET = 8'd8;
   localparam logic [DELAY_W-1:0]  RETURN_DELAY_RESET = 4'd0;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CREDIT_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETURN_DELAY = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FN_QUERY   = 2'd0,
      FN_ALLOC   = 2'd1,
      FN_RELEASE = 2'd2,
      FN_TICK    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_FULL  = 2'd2,
      ST_SAT   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TICK_RD,
      S_TICK_CHK,
      S_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // Pending queue commands
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } q_ctrl_type;

   // Pending queue status for the selected channel
   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

`default_nettype wire

/* sv/ccdr_if.sv */
// Interfaces: request and response channels of the credit counter block.
`default_nettype none

interface ccdr_req_if;
   import ccdr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [VC_FIELD_W-1:0] vc;
   logic [AMOUNT_W-1:0]   amount;

   modport source (output valid, output func, output vc, output amount, input ready);
   modport sink   (input valid, input func, input vc, input amount, output ready);
endinterface

interface ccdr_rsp_if;
   import ccdr_pkg::*;
   logic                valid;
   logic                ready;
   logic                granted;
   logic [CREDIT_W-1:0] credits_now;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output granted, output credits_now, output status,
                   input ready);
   modport sink   (input valid, input granted, input credits_now, input status,
                   output ready);
endinterface

`default_nettype wire

/* sv/ccdr_alu.sv */
// Shared add/subtract unit: saturating credit add or credit take with shortfall flag.
`default_nettype none

module ccdr_alu (
   input  ccdr_pkg::alu_op_type            op,
   input  logic [ccdr_pkg::CREDIT_W-1:0]   a,
   input  logic [ccdr_pkg::CREDIT_W-1:0]   b,
   input  logic [ccdr_pkg::CREDIT_W-1:0]   limit,
   output logic [ccdr_pkg::CREDIT_W-1:0]   result,
   output logic                            flag
);
   import ccdr_pkg::*;

   logic [CREDIT_W:0] sum;
   logic [CREDIT_W:0] diff;

   assign sum  = {1'b0, a} + {1'b0, b};
   assign diff = {1'b0, a} - {1'b0, b};

   // add: flag = saturated at limit; sub: flag = not enough credits (borrow)
   always_comb begin
      case (op)
         ALU_ADD: begin
            flag   = (sum > {1'b0, limit});
            result = flag ? limit : sum[CREDIT_W-1:0];
         end
         ALU_SUB: begin
            flag   = diff[CREDIT_W];
            result = diff[CREDIT_W-1:0];
         end
         default: begin
            flag   = 1'b0;
            result = a;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/ccdr_pend_queue.sv */
// Pending credit queues: per-channel head/tail/fill pointers over one shared entry memory.
`default_nettype none

module ccdr_pend_queue #(
   parameter int VC_COUNT      = ccdr_pkg::VC_COUNT_DEF,
   parameter int PENDING_DEPTH = ccdr_pkg::PENDING_DEPTH_DEF,
   localparam int VC_IW        = (VC_COUNT > 1) ? $clog2(VC_COUNT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ccdr_pkg::q_ctrl_type          ctrl,
   input  logic [VC_IW-1:0]              q_vc,
   input  logic [ccdr_pkg::DUE_W-1:0]    push_due,
   input  logic [ccdr_pkg::CREDIT_W-1:0] push_amount,
   output ccdr_pkg::q_stat_type          stat,
   output logic [ccdr_pkg::DUE_W-1:0]    rd_due,
   output logic [ccdr_pkg::CREDIT_W-1:0] rd_amount
);
   import ccdr_pkg::*;

   localparam int PTR_W     = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int FILL_W    = $clog2(PENDING_DEPTH + 1);
   localparam int ADDR_W    = VC_IW + PTR_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int ENTRY_W   = DUE_W + CREDIT_W;

   logic [PTR_W-1:0]   head_ff [VC_COUNT];
   logic [PTR_W-1:0]   head_in [VC_COUNT];
   logic [PTR_W-1:0]   tail_ff [VC_COUNT];
   logic [PTR_W-1:0]   tail_in [VC_COUNT];
   logic [FILL_W-1:0]  fill_ff [VC_COUNT];
   logic [FILL_W-1:0]  fill_in [VC_COUNT];
   logic [ENTRY_W-1:0] pend_mem_ff [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_entry_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      n = (p == PTR_W'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   // Status of the selected channel
   assign stat.empty = (fill_ff[q_vc] == '0);
   assign stat.full  = (fill_ff[q_vc] == FILL_W'(PENDING_DEPTH));

   // Pointer next values
   always_comb begin
      for (int c = 0; c < VC_COUNT; c++) begin
         head_in[c] = head_ff[c];
         tail_in[c] = tail_ff[c];
         fill_in[c] = fill_ff[c];
         if (ctrl.clear) begin
            head_in[c] = '0;
            tail_in[c] = '0;
            fill_in[c] = '0;
         end else if (VC_IW'(c) == q_vc) begin
            if (ctrl.push) begin
               tail_in[c] = next_ptr(tail_ff[c]);
               fill_in[c] = fill_ff[c] + 1'b1;
            end else if (ctrl.pop) begin
               head_in[c] = next_ptr(head_ff[c]);
               fill_in[c] = fill_ff[c] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < VC_COUNT; c++) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
            fill_ff[c] <= '0;
         end
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // Entry memory: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         pend_mem_ff[{q_vc, tail_ff[q_vc]}] <= {push_due, push_amount};
      end
      rd_entry_ff <= pend_mem_ff[{q_vc, head_ff[q_vc]}];
   end

   assign rd_due    = rd_entry_ff[ENTRY_W-1:CREDIT_W];
   assign rd_amount = rd_entry_ff[CREDIT_W-1:0];

endmodule

`default_nettype wire

/* sv/vc_credit_counter_delayed_return_core.sv */
// Top level: per-channel credit counters with delayed credit return.
// Query, allocate and release go from the accepted request beat through the execute
// and done states into the response register. A tick walks the channels one after
// another through one shared adder and the pending memory: each channel's queue head
// is read, and while that head is due it is returned and the next head read.
// Pending entries carry a due stamp against a free-running tick count instead of a
// countdown, so a tick touches only queue heads. One request is in work at a time; a
// finished response waits in an output register while the next request is accepted.
// Writing credit_limit reloads every counter and empties every pending queue at once.
`default_nettype none

module vc_credit_counter_delayed_return_core #(
   parameter int VC_COUNT      = ccdr_pkg::VC_COUNT_DEF,
   parameter int PENDING_DEPTH = ccdr_pkg::PENDING_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ccdr_req_if.sink                         req_ch,
   ccdr_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [ccdr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ccdr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ccdr_pkg::*;

   localparam int VC_IW = (VC_COUNT > 1) ? $clog2(VC_COUNT) : 1;

   state_type             state_ff, state_in;
   logic [FUNC_W-1:0]     func_ff;
   logic [VC_FIELD_W-1:0] vc_ff;
   logic [AMOUNT_W-1:0]   amount_ff;
   logic [CREDIT_W-1:0]   limit_ff;
   logic [DELAY_W-1:0]    delay_ff;
   logic [DUE_W-1:0]      tick_ff;
   logic [VC_IW-1:0]      chan_ff, chan_in;
   logic                  granted_ff, granted_in;
   status_type            status_ff, status_in;
   logic [CREDIT_W-1:0]   count_ff [VC_COUNT];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_granted_ff;
   logic [CREDIT_W-1:0]   rsp_credits_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic                  req_beat;
   logic                  limit_wr;
   logic                  vc_ok;
   logic [VC_IW-1:0]      vc_idx;
   logic                  in_tick;
   logic [VC_IW-1:0]      cnt_sel;
   logic [CREDIT_W-1:0]   cnt_rd;
   logic                  cnt_we;
   logic                  last_chan;
   logic                  rsp_load;
   logic [DUE_W-1:0]      due_diff;
   logic                  entry_ready;

   alu_op_type            alu_op;
   logic [CREDIT_W-1:0]   alu_b;
   logic [CREDIT_W-1:0]   alu_result;
   logic                  alu_flag;

   q_ctrl_type            q_ctrl;
   q_stat_type            q_stat;
   logic [DUE_W-1:0]      rd_due;
   logic [CREDIT_W-1:0]   rd_amount;

   // Handshake and decode
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_beat     = req_ch.valid && req_ch.ready;
   assign limit_wr     = csr_we && (csr_index == CSR_CREDIT_LIMIT);
   assign vc_ok        = (int'(vc_ff) < VC_COUNT);
   assign vc_idx       = VC_IW'(vc_ff);
   assign in_tick      = (state_ff == S_TICK_RD) || (state_ff == S_TICK_CHK);
   assign cnt_sel      = in_tick ? chan_ff : vc_idx;
   assign cnt_rd       = count_ff[cnt_sel];
   assign last_chan    = (chan_ff == VC_IW'(VC_COUNT - 1));
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Head entry is due once the tick count has reached its stamp
   assign due_diff    = rd_due - tick_ff;
   assign entry_ready = (due_diff == '0) || due_diff[DUE_W-1];

   // Shared arithmetic unit
   assign alu_op = ((state_ff == S_EXEC) &&
                    ((func_ff == FN_QUERY) || (func_ff == FN_ALLOC))) ? ALU_SUB : ALU_ADD;
   assign alu_b  = (state_ff == S_TICK_CHK) ? rd_amount : amount_ff;

   ccdr_alu u_alu (
      .op     (alu_op),
      .a      (cnt_rd),
      .b      (alu_b),
      .limit  (limit_ff),
      .result (alu_result),
      .flag   (alu_flag)
   );

   ccdr_pend_queue #(
      .VC_COUNT      (VC_COUNT),
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (q_ctrl),
      .q_vc        (cnt_sel),
      .push_due    (tick_ff + DUE_W'(delay_ff)),
      .push_amount (amount_ff),
      .stat        (q_stat),
      .rd_due      (rd_due),
      .rd_amount   (rd_amount)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in = (func_type'(req_ch.func) == FN_TICK) ? S_TICK_RD : S_EXEC;
            end
         end
         S_EXEC: state_in = S_DONE;
         S_TICK_RD: begin
            if (!q_stat.empty) begin
               state_in = S_TICK_CHK;
            end else if (last_chan) begin
               state_in = S_DONE;
            end
         end
         S_TICK_CHK: begin
            if (entry_ready || !last_chan) begin
               state_in = S_TICK_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      chan_in      = chan_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      cnt_we       = 1'b0;
      q_ctrl       = '0;
      q_ctrl.clear = limit_wr;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               chan_in    = '0;
               granted_in = 1'b0;
               status_in  = ST_OK;
            end
         end
         S_EXEC: begin
            if (vc_ok) begin
               case (func_type'(func_ff))
                  FN_QUERY, FN_ALLOC: begin
                     granted_in = !alu_flag;
                     status_in  = alu_flag ? ST_SHORT : ST_OK;
                     cnt_we     = (func_ff == FN_ALLOC) && !alu_flag;
                  end
                  FN_RELEASE: begin
                     if (delay_ff == '0) begin
                        cnt_we    = 1'b1;
                        status_in = alu_flag ? ST_SAT : ST_OK;
                     end else if (q_stat.full) begin
                        status_in = ST_FULL;
                     end else begin
                        q_ctrl.push = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TICK_RD: begin
            if (q_stat.empty && !last_chan) begin
               chan_in = chan_ff + 1'b1;
            end
         end
         S_TICK_CHK: begin
            if (entry_ready) begin
               cnt_we     = 1'b1;
               q_ctrl.pop = 1'b1;
               if (alu_flag) begin
                  status_in = ST_SAT;
               end
            end else if (!last_chan) begin
               chan_in = chan_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         limit_ff     <= CREDIT_LIMIT_RESET;
         delay_ff     <= RETURN_DELAY_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_beat && (func_type'(req_ch.func) == FN_TICK)) begin
            tick_ff <= tick_ff + 1'b1;
         end
         if (limit_wr) begin
            limit_ff <= csr_data;
         end
         if (csr_we && (csr_index == CSR_RETURN_DELAY)) begin
            delay_ff <= csr_data[DELAY_W-1:0];
         end
      end
   end

   // Credit counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < VC_COUNT; c++) begin
            count_ff[c] <= CREDIT_LIMIT_RESET;
         end
      end else if (limit_wr) begin
         for (int c = 0; c < VC_COUNT; c++) begin
            count_ff[c] <= csr_data;
         end
      end else if (cnt_we) begin
         count_ff[cnt_sel] <= alu_result;
      end
   end

   // Request and working payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff   <= req_ch.func;
         vc_ff     <= req_ch.vc;
         amount_ff <= req_ch.amount;
      end
      chan_ff    <= chan_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
      if (rsp_load) begin
         rsp_granted_ff <= granted_ff;
         rsp_credits_ff <= vc_ok ? cnt_rd : '0;
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.granted     = rsp_granted_ff;
   assign rsp_ch.credits_now = rsp_credits_ff;
   assign rsp_ch.status      = rsp_status_ff;

endmodule

`default_nettype wire

/* sv/ccdr_checker.sv */
// Port checker for the credit counter block, attached to the top level by bind.
`default_nettype none

module ccdr_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_granted,
   input  logic [ccdr_pkg::CREDIT_W-1:0] rsp_credits_now,
   input  logic [ccdr_pkg::STATUS_W-1:0] rsp_status
);
   import ccdr_pkg::*;

   // One request in work at a time: ready drops after a request beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one still in work");

   // A grant always comes with ok status
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted) |-> (rsp_status == ST_OK))
      else $error("granted response with error status");

   // Stalled response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // Stalled response payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_granted) && $stable(rsp_credits_now) && $stable(rsp_status)))
      else $error("response payload changed while stalled");

endmodule

bind vc_credit_counter_delayed_return_core ccdr_checker u_ccdr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_granted     (rsp_ch.granted),
   .rsp_credits_now (rsp_ch.credits_now),
   .rsp_status      (rsp_ch.status)
);

`default_nettype wire

/* sim/vc_credit_counter_delayed_return_core_tb.sv */
`timescale 1ns / 1ps
// Testbench for the per-channel credit counter with delayed credit return.

module vc_credit_counter_delayed_return_core_tb;
   import ccdr_pkg::*;

   localparam int NUM_VC          = VC_COUNT_DEF;
   localparam int QDEPTH          = PENDING_DEPTH_DEF;
   localparam int IDLE_GAP        = 4;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int END_CYCLES      = 100;
   localparam int MAX_PRINTS      = 40;

   // One response beat as the block should produce it
   typedef struct packed {
      logic [31:0]         beat_no;
      logic                granted;
      logic [CREDIT_W-1:0] credits;
      status_type          status;
   } credit_reply_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   ccdr_req_if req_ch();
   ccdr_rsp_if rsp_ch();

   vc_credit_counter_delayed_return_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Predicted credit state
   logic [CREDIT_W-1:0] limit_reg;
   logic [DELAY_W-1:0]  delay_reg;
   logic [CREDIT_W-1:0] vc_credits  [NUM_VC];
   logic [DELAY_W-1:0]  defer_ticks [NUM_VC][QDEPTH];
   logic [AMOUNT_W-1:0] defer_amount[NUM_VC][QDEPTH];
   int                  defer_head  [NUM_VC];
   int                  defer_tail  [NUM_VC];
   int                  defer_fill  [NUM_VC];

   credit_reply_type credit_replies_q[$];

   // Run bookkeeping
   bit req_steady;
   bit rsp_steady;
   bit hold_rsp_req;
   int error_count;
   int beats_sent;
   int replies_checked;
   int settings_written;
   int func_seen[4];
   int status_seen[4];

   task automatic report_error(string what);
      if (error_count < MAX_PRINTS)
         $display("ERROR t=%0t %s", $time, what);
      error_count++;
   endtask

   function automatic int draw_gap(bit steady);
      if (steady)
         return 0;
      if ($urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   // ---------------------------------------------------------------
   // Credit predictor
   // ---------------------------------------------------------------
   function automatic void reload_credits();
      for (int c = 0; c < NUM_VC; c++) begin
         vc_credits[c] = limit_reg;
         defer_head[c] = 0;
         defer_tail[c] = 0;
         defer_fill[c] = 0;
      end
   endfunction

   // Adds credits, clamped at the limit; returns 1 when clamped
   function automatic logic return_credits(int c, logic [AMOUNT_W-1:0] n);
      int sum;
      sum = int'(vc_credits[c]) + int'(n);
      if (sum > int'(limit_reg)) begin
         vc_credits[c] = limit_reg;
         return 1'b1;
      end
      vc_credits[c] = sum[CREDIT_W-1:0];
      return 1'b0;
   endfunction

   function automatic void apply_reg_write(logic [CSR_INDEX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_CREDIT_LIMIT) begin
         limit_reg = val;
         reload_credits();
      end else if (idx == CSR_RETURN_DELAY) begin
         delay_reg = val[DELAY_W-1:0];
      end
   endfunction

   function automatic credit_reply_type next_credit_reply(func_type fn,
                                                          logic [VC_FIELD_W-1:0] vc,
                                                          logic [AMOUNT_W-1:0] amt);
      credit_reply_type r;
      logic             sat;
      int               idx;
      int               ch;
      ch        = int'(vc);
      r         = '0;
      r.status  = ST_OK;
      case (fn)
         FN_QUERY, FN_ALLOC: begin
            if (vc_credits[ch] >= amt) begin
               r.granted = 1'b1;
               if (fn == FN_ALLOC)
                  vc_credits[ch] = vc_credits[ch] - amt;
            end else begin
               r.status = ST_SHORT;
            end
         end
         FN_RELEASE: begin
            if (delay_reg == '0) begin
               if (return_credits(ch, amt))
                  r.status = ST_SAT;
            end else if (defer_fill[ch] >= QDEPTH) begin
               r.status = ST_FULL;
            end else begin
               defer_ticks[ch][defer_tail[ch]]  = delay_reg;
               defer_amount[ch][defer_tail[ch]] = amt;
               defer_tail[ch] = (defer_tail[ch] + 1) % QDEPTH;
               defer_fill[ch]++;
            end
         end
         FN_TICK: begin
            sat = 1'b0;
            for (int c = 0; c < NUM_VC; c++) begin
               // count down every queued entry, then retire ready heads
               idx = defer_head[c];
               for (int k = 0; k < defer_fill[c]; k++) begin
                  if (defer_ticks[c][idx] != '0)
                     defer_ticks[c][idx]--;
                  idx = (idx + 1) % QDEPTH;
               end
               while (defer_fill[c] > 0 && defer_ticks[c][defer_head[c]] == '0) begin
                  if (return_credits(c, defer_amount[c][defer_head[c]]))
                     sat = 1'b1;
                  defer_head[c] = (defer_head[c] + 1) % QDEPTH;
                  defer_fill[c]--;
               end
            end
            if (sat)
               r.status = ST_SAT;
         end
         default: ;
      endcase
      r.credits = vc_credits[ch];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   task automatic send_beat(func_type fn, logic [VC_FIELD_W-1:0] vc,
                            logic [AMOUNT_W-1:0] amt);
      int               gap;
      credit_reply_type want;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.func   <= fn;
      req_ch.vc     <= vc;
      req_ch.amount <= amt;
      do @(posedge clock); while (!req_ch.ready);
      want         = next_credit_reply(fn, vc, amt);
      want.beat_no = beats_sent;
      credit_replies_q.insert(credit_replies_q.size(), want);
      beats_sent++;
      func_seen[int'(fn)]++;
      status_seen[int'(want.status)]++;
      @(negedge clock);
   endtask

   task automatic send_random_beat();
      func_type              fn;
      logic [VC_FIELD_W-1:0] vc;
      logic [AMOUNT_W-1:0]   amt;
      int                    pick;
      pick = $urandom_range(0, 99);
      if (pick < 20)      fn = FN_QUERY;
      else if (pick < 50) fn = FN_ALLOC;
      else if (pick < 78) fn = FN_RELEASE;
      else                fn = FN_TICK;
      vc   = VC_FIELD_W'($urandom_range(0, NUM_VC - 1));
      pick = $urandom_range(0, 9);
      // mostly amounts up to half the limit plus one, some full range and extremes
      if (pick == 0)
         amt = AMOUNT_W'($urandom_range(0, 255));
      else if (pick == 1)
         amt = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      else
         amt = AMOUNT_W'($urandom_range(0, (int'(limit_reg) >> 1) + 1));
      send_beat(fn, vc, amt);
   endtask

   // Lowers valid and waits until every response beat is back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (credit_replies_q.size() != 0) @(negedge clock);
      repeat (IDLE_GAP) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      apply_reg_write(idx, val);
      settings_written++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // Response side: random stalls plus one long hold on request
   // ---------------------------------------------------------------
   initial begin : rsp_drain
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp_req = 1'b0;
         end
         stall = draw_gap(rsp_steady);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // Compare each response beat against the oldest prediction
   always @(posedge clock) begin : rsp_check
      credit_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (credit_replies_q.size() == 0) begin
            report_error("response beat with no prediction waiting");
         end else begin
            want = credit_replies_q[0];
            credit_replies_q.delete(0);
            if (rsp_ch.granted !== want.granted)
               report_error($sformatf("beat %0d: granted got %b expected %b",
                                      want.beat_no, rsp_ch.granted, want.granted));
            if (rsp_ch.credits_now !== want.credits)
               report_error($sformatf("beat %0d: credits_now got %0d expected %0d",
                                      want.beat_no, rsp_ch.credits_now, want.credits));
            if (rsp_ch.status !== want.status)
               report_error($sformatf("beat %0d: status got %0d expected %0d",
                                      want.beat_no, rsp_ch.status, want.status));
         end
         replies_checked++;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Counters start at the reset limit; immediate return with delay zero
   task automatic test_immediate_credits();
      send_beat(FN_QUERY,   2'd0, 8'd8);
      send_beat(FN_QUERY,   2'd1, 8'd9);
      send_beat(FN_QUERY,   2'd2, 8'd0);
      send_beat(FN_ALLOC,   2'd3, 8'd255);
      send_beat(FN_ALLOC,   2'd3, 8'd5);
      send_beat(FN_ALLOC,   2'd3, 8'd0);
      send_beat(FN_RELEASE, 2'd3, 8'd255);
      send_beat(FN_RELEASE, 2'd0, 8'd0);
      send_beat(FN_TICK,    2'd1, 8'd0);
   endtask

   // Fill one pending queue past its depth, then drain it by ticks
   task automatic test_pending_queue();
      wait_idle();
      write_reg(CSR_RETURN_DELAY, 8'd2);
      send_beat(FN_ALLOC, 2'd2, 8'd8);
      repeat (QDEPTH + 1) send_beat(FN_RELEASE, 2'd2, 8'd1);
      send_beat(FN_TICK, 2'd2, 8'd0);
      send_beat(FN_TICK, 2'd2, 8'd0);
   endtask

   // A zero limit is legal: nothing can be taken, any nonzero return saturates
   task automatic test_zero_limit();
      wait_idle();
      write_reg(CSR_CREDIT_LIMIT, 8'd0);
      write_reg(CSR_RETURN_DELAY, 8'd0);
      send_beat(FN_QUERY,   2'd0, 8'd0);
      send_beat(FN_ALLOC,   2'd1, 8'd1);
      send_beat(FN_RELEASE, 2'd2, 8'd1);
   endtask

   // One random phase under a given setting; a negative limit keeps the
   // current limit so queued entries survive into the phase
   task automatic run_phase(int limit_val, int delay_val, int items, bit steady);
      wait_idle();
      if (limit_val >= 0)
         write_reg(CSR_CREDIT_LIMIT, 8'(limit_val));
      write_reg(CSR_RETURN_DELAY, 8'(delay_val));
      req_steady = steady;
      rsp_steady = steady;
      repeat (items) send_random_beat();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   task automatic test_random_settings();
      run_phase(255, 0, 250, 1'b0);
      run_phase(1, 1, 200, 1'b1);
      run_phase(8, 15, 250, 1'b0);
      run_phase(255, 15, 200, 1'b0);
      // ticks with zero delay still drain what the last phase queued
      run_phase(-1, 0, 150, 1'b0);
      run_phase($urandom_range(2, 254), $urandom_range(1, 14), 250, 1'b0);
      run_phase($urandom_range(1, 255), $urandom_range(0, 15), 250, 1'b0);
      run_phase(40, 4, 250, 1'b0);
   endtask

   // Response side holds off while requests keep coming back to back
   task automatic test_output_backpressure();
      wait_idle();
      hold_rsp_req = 1'b1;
      req_steady   = 1'b1;
      repeat (40) send_random_beat();
      req_steady   = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin : test_sequence
      int waited;
      req_ch.valid  = 1'b0;
      req_ch.func   = FN_QUERY;
      req_ch.vc     = '0;
      req_ch.amount = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_CREDIT_LIMIT;
      csr_data      = '0;
      reset         = 1'b1;
      limit_reg     = CREDIT_LIMIT_RESET;
      delay_reg     = RETURN_DELAY_RESET;
      reload_credits();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      test_immediate_credits();
      test_pending_queue();
      test_zero_limit();
      test_random_settings();
      test_output_backpressure();

      // let every response come home, then a little more
      req_ch.valid <= 1'b0;
      waited = 0;
      while (credit_replies_q.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (END_CYCLES) @(negedge clock);
      if (credit_replies_q.size() != 0)
         report_error($sformatf("%0d predicted responses never arrived",
                                credit_replies_q.size()));

      $display("Covered %0d request beats (query %0d, allocate %0d, release %0d, tick %0d),",
               beats_sent, func_seen[FN_QUERY], func_seen[FN_ALLOC],
               func_seen[FN_RELEASE], func_seen[FN_TICK]);
      $display("%0d responses checked: %0d short, %0d queue full, %0d saturated; %0d writes.",
               replies_checked, status_seen[ST_SHORT], status_seen[ST_FULL],
               status_seen[ST_SAT], settings_written);
      if (error_count == 0)
         $display("vc_credit_counter_delayed_return_core: match");
      else
         $display("vc_credit_counter_delayed_return_core: mismatch");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #3_000_000;
      $display("ERROR: run did not finish in time");
      $display("vc_credit_counter_delayed_return_core: mismatch");
      $finish;
   end

endmodule

/* sim.f */
sv/ccdr_pkg.sv
sv/ccdr_if.sv
sv/ccdr_alu.sv
sv/ccdr_pend_queue.sv
sv/vc_credit_counter_delayed_return_core.sv
sv/ccdr_checker.sv
sim/vc_credit_counter_delayed_return_core_tb.sv
